[hw/rtl/stal_pkg.sv]
// Shared types and constants of the segment time allocator.
package stal_pkg;

	localparam int REG_WIDTH = 32;
	// The cube root works on a fixed 96-bit radicand and yields 32 root bits.
	localparam int CB_BITS  = 96;
	localparam int CB_STEPS = 32;

	typedef logic [2:0] reg_index_t;
	localparam reg_index_t REG_VELOCITY     = 3'd0;
	localparam reg_index_t REG_ACCELERATION = 3'd1;
	localparam reg_index_t REG_JERK         = 3'd2;
	localparam reg_index_t REG_FLOOR        = 3'd3;
	localparam reg_index_t REG_SCALE        = 3'd4;
	localparam reg_index_t REG_TOLERANCE    = 3'd5;

	typedef enum logic [2:0] {
		REC_DIV  = 3'b001,
		REC_SQRT = 3'b010,
		REC_CBRT = 3'b100
	} rec_mode_t;

	typedef struct packed {
		logic      start;
		rec_mode_t mode;
	} rec_cmd_t;

endpackage

[hw/rtl/stal_smul.sv]
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module stal_smul #(
	parameter int MW = 33
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [MW-1:0]   a,
	input  logic [MW-1:0]   b,
	output logic            done,
	output logic [2*MW-1:0] product
);

	localparam int CNW = $clog2(MW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNW-1:0]  cnt_q;
	logic [2*MW-1:0] acc_q;
	logic [2*MW-1:0] mcand_q;
	logic [MW-1:0]   mplier_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNW'(MW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNW'(1);
				if (cnt_q == CNW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= (2*MW)'(a);
			mplier_q <= b;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

[hw/rtl/stal_rec.sv]
// Shared digit-recurrence unit: restoring division, square root and cube root.
module stal_rec #(
	parameter int UW = 96
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  stal_pkg::rec_cmd_t        cmd,
	input  logic [$clog2(UW+1)-1:0]   steps,
	input  logic [UW-1:0]             operand,
	input  logic [31:0]               divisor,
	output logic                      done,
	output logic [UW-1:0]             result
);

	localparam int RW  = UW + 4;
	localparam int SCW = $clog2(UW + 1);

	logic                busy_q;
	logic                done_q;
	logic [SCW-1:0]      cnt_q;
	stal_pkg::rec_mode_t mode_q;
	logic [UW-1:0]       opd_q;
	logic [31:0]         div_q;
	logic [RW-1:0]       rem_q;
	logic [RW-1:0]       root_q;
	logic [RW-1:0]       y2_q;

	logic [RW-1:0] rs;
	logic [RW-1:0] trial;
	logic [RW-1:0] diff;
	logic          take;

	// Operand bits enter from the top: one for division, two for the square
	// root, three for the cube root.
	always_comb begin
		rs    = '0;
		trial = '0;
		case (mode_q)
			stal_pkg::REC_DIV: begin
				rs    = {rem_q[RW-2:0], opd_q[UW-1]};
				trial = RW'(div_q);
			end
			stal_pkg::REC_SQRT: begin
				rs    = {rem_q[RW-3:0], opd_q[UW-1 -: 2]};
				trial = {root_q[RW-3:0], 2'b01};
			end
			stal_pkg::REC_CBRT: begin
				rs    = {rem_q[RW-4:0], opd_q[UW-1 -: 3]};
				trial = (y2_q << 3) + (y2_q << 2) + (root_q << 2) + (root_q << 1) + RW'(1);
			end
			default: begin
				rs    = '0;
				trial = '0;
			end
		endcase
		take = (rs >= trial);
		diff = rs - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - SCW'(1);
				if (cnt_q == SCW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mode_q <= cmd.mode;
			opd_q  <= operand;
			div_q  <= divisor;
			rem_q  <= '0;
			root_q <= '0;
			y2_q   <= '0;
		end else if (busy_q) begin
			rem_q  <= take ? diff : rs;
			root_q <= {root_q[RW-2:0], take};
			if (mode_q == stal_pkg::REC_CBRT) begin
				// Square of the root follows it: (2y+1)^2 = 4y^2 + 4y + 1.
				y2_q  <= take ? ((y2_q << 2) + (root_q << 2) + RW'(1)) : (y2_q << 2);
				opd_q <= opd_q << 3;
			end else if (mode_q == stal_pkg::REC_SQRT) begin
				opd_q <= opd_q << 2;
			end else begin
				opd_q <= opd_q << 1;
			end
		end
	end

	assign done   = done_q;
	assign result = root_q[UW-1:0];

endmodule

[hw/rtl/segment_time_allocator.sv]
// Top level of the segment time allocator: control sequence, registers and ports.
//
//  Channel   Direction  Handshake                  Carries
//  s_axis    in         s_axis_tvalid/tready       waypoint x, y, z; tuser: path_start
//  m_axis    out        m_axis_tvalid/tready       segment duration; tuser: short, saturated
//  cfg       in         cfg_valid/cfg_ready        register index and 32-bit write data
//
// One waypoint is processed at a time; a waypoint that starts a path only stores its point.
// A full segment runs the squares, the length root, the short check, the division by the
// velocity limit, the division by the acceleration limit and its square root, the division
// by the jerk limit and its cube root, the scaling and the hand-over to the output register.
// A short segment ends after the length root; a zero limit skips its recurrence.
// Reset is asynchronous and active low, restores the default limits and drops the previous
// waypoint. A stalled result does not block the input; the next result waits in the
// sequencer until the output register is free.
module segment_time_allocator #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic clk,
	input  logic arst_n,
	// point_x, point_y, point_z from bit 0 up, zero padded to whole bytes
	input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	input  logic [0:0]  s_axis_tuser,  // path_start
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	output logic [31:0] m_axis_tdata,  // segment_duration
	output logic [1:0]  m_axis_tuser,  // short_segment, saturated
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int CW   = COORD_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int DFW  = CW + 1;            // width of a coordinate difference
	localparam int SW   = 2*DFW + 2;         // width of the sum of squares
	localparam int DLW  = SW / 2;            // width of the segment length
	localparam int DW   = DLW + 3*F + 5;     // width of the widest dividend
	localparam int DWE  = DW + (DW % 2);
	localparam int UW0  = (SW > DWE) ? SW : DWE;
	localparam int UW   = (UW0 > stal_pkg::CB_BITS) ? UW0 : stal_pkg::CB_BITS;
	localparam int SCW  = $clog2(UW + 1);
	localparam int MW   = (DFW > 32) ? DFW : 32;
	localparam int CPW  = (DLW > 32) ? DLW : 32;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_SQR   = 11'b000_0000_0010,
		ST_ROOT  = 11'b000_0000_0100,
		ST_CHECK = 11'b000_0000_1000,
		ST_DIVV  = 11'b000_0001_0000,
		ST_DIVA  = 11'b000_0010_0000,
		ST_SQA   = 11'b000_0100_0000,
		ST_DIVJ  = 11'b000_1000_0000,
		ST_CBRT  = 11'b001_0000_0000,
		ST_SCALE = 11'b010_0000_0000,
		ST_OUT   = 11'b100_0000_0000
	} state_t;

	state_t      state_q;
	logic        go_q;
	logic [1:0]  sq_idx_q;
	logic        have_prev_q;
	logic        out_valid_q;

	logic [31:0] vel_q, acc_q, jerk_q, floor_q, scale_q, tol_q;

	logic [CW-1:0]  prev_x_q, prev_y_q, prev_z_q;
	logic [DFW-1:0] diff_q [3];
	logic [SW-1:0]  sum_q;
	logic [DLW-1:0] d_q;
	logic [31:0]    lb_q;
	logic           sat_q;
	logic           short_q;
	logic [31:0]    dur_q;
	logic [31:0]    out_dur_q;
	logic           out_short_q;
	logic           out_sat_q;

	// Input view
	logic [CW-1:0]  px, py, pz;
	logic [DFW-1:0] sdx, sdy, sdz;
	logic           in_acc;
	logic           new_path;

	assign px = s_axis_tdata[CW-1:0];
	assign py = s_axis_tdata[2*CW-1:CW];
	assign pz = s_axis_tdata[3*CW-1:2*CW];

	// Signed differences, one bit wider than the coordinates, so that the
	// magnitude always fits.
	assign sdx = {px[CW-1], px} - {prev_x_q[CW-1], prev_x_q};
	assign sdy = {py[CW-1], py} - {prev_y_q[CW-1], prev_y_q};
	assign sdz = {pz[CW-1], pz} - {prev_z_q[CW-1], prev_z_q};

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign new_path      = s_axis_tuser[0] || !have_prev_q;
	assign cfg_ready     = 1'b1;

	// Shared units
	logic            mul_start;
	logic [MW-1:0]   mul_a, mul_b;
	logic            mul_done;
	logic [2*MW-1:0] mul_prod;

	stal_pkg::rec_cmd_t rec_cmd;
	logic [SCW-1:0]     rec_steps;
	logic [UW-1:0]      rec_opd;
	logic [31:0]        rec_div;
	logic               rec_done;
	logic [UW-1:0]      rec_res;

	stal_smul #(.MW(MW)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_prod)
	);

	stal_rec #(.UW(UW)) u_rec (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (rec_cmd),
		.steps   (rec_steps),
		.operand (rec_opd),
		.divisor (rec_div),
		.done    (rec_done),
		.result  (rec_res)
	);

	// The multiplier squares the differences in turn, then scales the bound.
	always_comb begin
		if (state_q == ST_SCALE) begin
			mul_a = MW'(lb_q);
			mul_b = MW'(scale_q);
		end else begin
			mul_a = MW'(diff_q[sq_idx_q]);
			mul_b = MW'(diff_q[sq_idx_q]);
		end
		mul_start = go_q && ((state_q == ST_SQR) || (state_q == ST_SCALE));
	end

	// Each recurrence is launched on the first cycle of its state. Operands are
	// left aligned so that their top bits enter first.
	always_comb begin
		rec_cmd.start = 1'b0;
		rec_cmd.mode  = stal_pkg::REC_DIV;
		rec_steps     = SCW'(DW);
		rec_opd       = '0;
		rec_div       = '0;
		case (state_q)
			ST_ROOT: begin
				rec_cmd.start = go_q;
				rec_cmd.mode  = stal_pkg::REC_SQRT;
				rec_steps     = SCW'(SW / 2);
				rec_opd       = UW'(sum_q) << (UW - SW);
			end
			ST_DIVV: begin
				rec_cmd.start = go_q && (vel_q != '0);
				rec_opd       = UW'(DW'({d_q, {F{1'b0}}})) << (UW - DW);
				rec_div       = vel_q;
			end
			ST_DIVA: begin
				rec_cmd.start = go_q && (acc_q != '0);
				rec_opd       = UW'(DW'({d_q, {(2*F){1'b0}}})) << (UW - DW);
				rec_div       = acc_q;
			end
			ST_SQA: begin
				rec_cmd.start = go_q;
				rec_cmd.mode  = stal_pkg::REC_SQRT;
				rec_steps     = SCW'(DWE / 2);
				rec_opd       = rec_res << (UW - DWE);
			end
			ST_DIVJ: begin
				rec_cmd.start = go_q && (jerk_q != '0);
				rec_opd       = UW'(DW'({d_q, {(3*F+5){1'b0}}})) << (UW - DW);
				rec_div       = jerk_q;
			end
			ST_CBRT: begin
				rec_cmd.start = go_q;
				rec_cmd.mode  = stal_pkg::REC_CBRT;
				rec_steps     = SCW'(stal_pkg::CB_STEPS);
				rec_opd       = rec_res << (UW - stal_pkg::CB_BITS);
			end
			default: begin
				rec_cmd.start = 1'b0;
			end
		endcase
	end

	// Bounds taken from the recurrence result and the scaled product, with their overflow checks.
	logic        vb_ovf, ab_ovf, jq_ovf, sc_ovf, is_short;
	logic [31:0] vb, ab, sc, sc_sat;

	assign vb_ovf   = (rec_res >> 32) != '0;
	assign vb       = vb_ovf ? '1 : rec_res[31:0];
	assign ab_ovf   = (rec_res >> 31) != '0;
	assign ab       = ab_ovf ? '1 : {rec_res[30:0], 1'b0};
	assign jq_ovf   = (rec_res >> stal_pkg::CB_BITS) != '0;
	assign sc_ovf   = (mul_prod >> (32 + F)) != '0;
	assign sc       = mul_prod[F+31:F];
	assign sc_sat   = sc_ovf ? '1 : sc;
	assign is_short = CPW'(d_q) <= CPW'(tol_q);

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			go_q        <= 1'b0;
			sq_idx_q    <= '0;
			have_prev_q <= 1'b0;
			out_valid_q <= 1'b0;
			vel_q       <= 32'd131072;
			acc_q       <= 32'd131072;
			jerk_q      <= 32'd262144;
			floor_q     <= 32'd6554;
			scale_q     <= 32'd65536;
			tol_q       <= 32'd66;
		end else begin
			go_q <= 1'b0;
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					stal_pkg::REG_VELOCITY:     vel_q   <= cfg_data;
					stal_pkg::REG_ACCELERATION: acc_q   <= cfg_data;
					stal_pkg::REG_JERK:         jerk_q  <= cfg_data;
					stal_pkg::REG_FLOOR:        floor_q <= cfg_data;
					stal_pkg::REG_SCALE:        scale_q <= cfg_data;
					stal_pkg::REG_TOLERANCE:    tol_q   <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						have_prev_q <= 1'b1;
						if (!new_path) begin
							state_q  <= ST_SQR;
							go_q     <= 1'b1;
							sq_idx_q <= '0;
						end
					end
				end
				ST_SQR: begin
					if (mul_done) begin
						go_q <= 1'b1;
						if (sq_idx_q == 2'd2) begin
							state_q <= ST_ROOT;
						end else begin
							sq_idx_q <= sq_idx_q + 2'd1;
						end
					end
				end
				ST_ROOT: begin
					if (rec_done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					go_q    <= 1'b1;
					state_q <= is_short ? ST_OUT : ST_DIVV;
				end
				ST_DIVV: begin
					if ((go_q && vel_q == '0) || rec_done) begin
						state_q <= ST_DIVA;
						go_q    <= 1'b1;
					end
				end
				ST_DIVA: begin
					if (go_q && acc_q == '0) begin
						state_q <= ST_DIVJ;
						go_q    <= 1'b1;
					end else if (rec_done) begin
						state_q <= ST_SQA;
						go_q    <= 1'b1;
					end
				end
				ST_SQA: begin
					if (rec_done) begin
						state_q <= ST_DIVJ;
						go_q    <= 1'b1;
					end
				end
				ST_DIVJ: begin
					if ((go_q && jerk_q == '0) || (rec_done && jq_ovf)) begin
						state_q <= ST_SCALE;
						go_q    <= 1'b1;
					end else if (rec_done) begin
						state_q <= ST_CBRT;
						go_q    <= 1'b1;
					end
				end
				ST_CBRT: begin
					if (rec_done) begin
						state_q <= ST_SCALE;
						go_q    <= 1'b1;
					end
				end
				ST_SCALE: begin
					if (mul_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// Hold the result until the output register has been emptied.
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Data path
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					prev_x_q  <= px;
					prev_y_q  <= py;
					prev_z_q  <= pz;
					diff_q[0] <= sdx[DFW-1] ? -sdx : sdx;
					diff_q[1] <= sdy[DFW-1] ? -sdy : sdy;
					diff_q[2] <= sdz[DFW-1] ? -sdz : sdz;
					sum_q     <= '0;
				end
			end
			ST_SQR: begin
				if (mul_done) begin
					sum_q <= sum_q + SW'(mul_prod);
				end
			end
			ST_ROOT: begin
				if (rec_done) begin
					d_q <= rec_res[DLW-1:0];
				end
			end
			ST_CHECK: begin
				lb_q    <= '0;
				sat_q   <= 1'b0;
				short_q <= is_short;
				dur_q   <= floor_q;
			end
			ST_DIVV: begin
				if (go_q && vel_q == '0) begin
					lb_q  <= '1;
					sat_q <= 1'b1;
				end else if (rec_done) begin
					lb_q  <= vb;
					sat_q <= vb_ovf;
				end
			end
			ST_DIVA: begin
				if (go_q && acc_q == '0) begin
					lb_q  <= '1;
					sat_q <= 1'b1;
				end
			end
			ST_SQA: begin
				if (rec_done) begin
					if (ab > lb_q) begin
						lb_q <= ab;
					end
					if (ab_ovf) begin
						sat_q <= 1'b1;
					end
				end
			end
			ST_DIVJ: begin
				if ((go_q && jerk_q == '0) || (rec_done && jq_ovf)) begin
					lb_q  <= '1;
					sat_q <= 1'b1;
				end
			end
			ST_CBRT: begin
				if (rec_done && (rec_res[31:0] > lb_q)) begin
					lb_q <= rec_res[31:0];
				end
			end
			ST_SCALE: begin
				if (mul_done) begin
					dur_q <= (sc_sat < floor_q) ? floor_q : sc_sat;
					if (sc_ovf) begin
						sat_q <= 1'b1;
					end
				end
			end
			ST_OUT: begin
				if (!out_valid_q) begin
					out_dur_q   <= dur_q;
					out_short_q <= short_q;
					out_sat_q   <= sat_q;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_dur_q;
	assign m_axis_tuser  = {out_sat_q, out_short_q};

endmodule

[hw/rtl/stal_checker.sv]
// Port-level checks for the segment time allocator, bound to the top level.
module stal_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// A stalled result holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// A short segment is never reported as clamped.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("short segment marked saturated");

	// No result can appear in the cycle right after a waypoint is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
		else $error("result appeared too early");

endmodule

bind segment_time_allocator stal_checker u_stal_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
